@@ sv/rce_pkg.sv @@
// rce_pkg: shared types, register codes and fixed-point constants
// for the RGB color effect block. No dependencies.
package rce_pkg;

  localparam int ChanW    = 8;
  localparam int ModeW    = 3;
  localparam int PctW     = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam int NumChan  = 3;
  localparam int Latency  = 4;

  localparam logic [ChanW-1:0] ChanMax  = 8'd255;
  localparam logic [PctW-1:0]  PctReset = 8'd60;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE       = 3'd0,
    MODE_GRAY       = 3'd1,
    MODE_BLUE_TINT  = 3'd2,
    MODE_RED_TINT   = 3'd3,
    MODE_SEPIA      = 3'd4,
    MODE_BRIGHTEN   = 3'd5
  } effect_mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EFFECT_MODE = 2'd0,
    REG_BRIGHTEN    = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [PctW-1:0]  pct;
  } rce_cfg_t;

  // sepia matrix, thousandths; row = output channel, column = r, g, b
  localparam int CoefW = 10;
  localparam logic [CoefW-1:0] SepCoef [NumChan][NumChan] = '{
    '{10'd393, 10'd769, 10'd189},
    '{10'd349, 10'd686, 10'd168},
    '{10'd272, 10'd534, 10'd131}
  };

  // truncating divides by reciprocal multiply, exact over the value ranges used
  localparam int SumW      = 10;                 // r+g+b <= 765
  localparam int AvgRecipW = 10;
  localparam logic [AvgRecipW-1:0] AvgRecip = 10'd683;   // ceil(2^11/3)
  localparam int AvgShift  = 11;
  localparam int AvgProdW  = SumW + AvgRecipW;

  localparam int SepSumW   = 19;                 // <= 344505
  localparam int SepRecipW = 19;
  localparam logic [SepRecipW-1:0] SepRecip = 19'd268436; // ceil(2^28/1000)
  localparam int SepShift  = 28;
  localparam int SepProdW  = SepSumW + SepRecipW;
  localparam int SepQW     = 9;                  // quotient <= 344

  localparam int BrtProdW  = ChanW + PctW;       // c*p <= 65025
  localparam int BrtRecipW = 18;
  localparam logic [BrtRecipW-1:0] BrtRecip = 18'd167773; // ceil(2^24/100)
  localparam int BrtShift  = 24;
  localparam int BrtMulW   = BrtProdW + BrtRecipW;
  localparam int BrtQW     = 10;                 // quotient <= 650
  localparam int BrtSumW   = BrtQW + 1;

endpackage

@@ sv/rce_pipe.sv @@
// rce_pipe: four-stage color effect datapath (capture, products,
// reciprocal divides, select and saturate). Depends on rce_pkg.
module rce_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [rce_pkg::ChanW-1:0]     in_red,
  input  logic [rce_pkg::ChanW-1:0]     in_green,
  input  logic [rce_pkg::ChanW-1:0]     in_blue,
  input  rce_pkg::rce_cfg_t             cfg,
  output logic                          out_valid,
  output logic [rce_pkg::ChanW-1:0]     out_red,
  output logic [rce_pkg::ChanW-1:0]     out_green,
  output logic [rce_pkg::ChanW-1:0]     out_blue
);

  // stage 1: capture
  logic                          v1;
  logic [rce_pkg::ModeW-1:0]     mode1;
  logic [rce_pkg::PctW-1:0]      pct1;
  logic [rce_pkg::ChanW-1:0]     pix1 [rce_pkg::NumChan];

  // stage 2: sums and products
  logic                          v2;
  logic [rce_pkg::ModeW-1:0]     mode2;
  logic [rce_pkg::ChanW-1:0]     pix2 [rce_pkg::NumChan];
  logic [rce_pkg::SumW-1:0]      sum2;
  logic [rce_pkg::SepSumW-1:0]   sep2 [rce_pkg::NumChan];
  logic [rce_pkg::BrtProdW-1:0]  brt2 [rce_pkg::NumChan];
  logic [rce_pkg::SepSumW-1:0]   sep2_next [rce_pkg::NumChan];
  logic [rce_pkg::BrtProdW-1:0]  brt2_next [rce_pkg::NumChan];

  // stage 3: quotients
  logic                          v3;
  logic [rce_pkg::ModeW-1:0]     mode3;
  logic [rce_pkg::ChanW-1:0]     pix3 [rce_pkg::NumChan];
  logic [rce_pkg::ChanW-1:0]     avg3;
  logic [rce_pkg::SepQW-1:0]     sepq3 [rce_pkg::NumChan];
  logic [rce_pkg::BrtQW-1:0]     brtq3 [rce_pkg::NumChan];
  logic [rce_pkg::AvgProdW-1:0]  avg_prod;
  logic [rce_pkg::SepProdW-1:0]  sep_prod [rce_pkg::NumChan];
  logic [rce_pkg::BrtMulW-1:0]   brt_prod [rce_pkg::NumChan];

  // stage 4: select
  logic [rce_pkg::ChanW-1:0]     sep_sat [rce_pkg::NumChan];
  logic [rce_pkg::ChanW-1:0]     brt_sat [rce_pkg::NumChan];
  logic [rce_pkg::BrtSumW-1:0]   brt_sum [rce_pkg::NumChan];
  logic [rce_pkg::ChanW-1:0]     res_next [rce_pkg::NumChan];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    mode1   <= cfg.mode;
    pct1    <= cfg.pct;
    pix1[0] <= in_red;
    pix1[1] <= in_green;
    pix1[2] <= in_blue;
  end

  always_comb begin
    for (int i = 0; i < rce_pkg::NumChan; i++) begin
      sep2_next[i] =
          rce_pkg::SepSumW'(pix1[0]) * rce_pkg::SepSumW'(rce_pkg::SepCoef[i][0])
        + rce_pkg::SepSumW'(pix1[1]) * rce_pkg::SepSumW'(rce_pkg::SepCoef[i][1])
        + rce_pkg::SepSumW'(pix1[2]) * rce_pkg::SepSumW'(rce_pkg::SepCoef[i][2]);
      brt2_next[i] = rce_pkg::BrtProdW'(pix1[i]) * rce_pkg::BrtProdW'(pct1);
    end
  end

  always_ff @(posedge clk) begin
    mode2 <= mode1;
    sum2  <= rce_pkg::SumW'(pix1[0]) + rce_pkg::SumW'(pix1[1]) + rce_pkg::SumW'(pix1[2]);
    for (int i = 0; i < rce_pkg::NumChan; i++) begin
      pix2[i] <= pix1[i];
      sep2[i] <= sep2_next[i];
      brt2[i] <= brt2_next[i];
    end
  end

  always_comb begin
    avg_prod = rce_pkg::AvgProdW'(sum2) * rce_pkg::AvgProdW'(rce_pkg::AvgRecip);
    for (int i = 0; i < rce_pkg::NumChan; i++) begin
      sep_prod[i] = rce_pkg::SepProdW'(sep2[i]) * rce_pkg::SepProdW'(rce_pkg::SepRecip);
      brt_prod[i] = rce_pkg::BrtMulW'(brt2[i]) * rce_pkg::BrtMulW'(rce_pkg::BrtRecip);
    end
  end

  always_ff @(posedge clk) begin
    mode3 <= mode2;
    avg3  <= avg_prod[rce_pkg::AvgShift +: rce_pkg::ChanW];
    for (int i = 0; i < rce_pkg::NumChan; i++) begin
      pix3[i]  <= pix2[i];
      sepq3[i] <= sep_prod[i][rce_pkg::SepShift +: rce_pkg::SepQW];
      brtq3[i] <= brt_prod[i][rce_pkg::BrtShift +: rce_pkg::BrtQW];
    end
  end

  always_comb begin
    for (int i = 0; i < rce_pkg::NumChan; i++) begin
      sep_sat[i] = (sepq3[i] > rce_pkg::SepQW'(rce_pkg::ChanMax))
                 ? rce_pkg::ChanMax : sepq3[i][rce_pkg::ChanW-1:0];
      brt_sum[i] = rce_pkg::BrtSumW'(pix3[i]) + rce_pkg::BrtSumW'(brtq3[i]);
      brt_sat[i] = (brt_sum[i] > rce_pkg::BrtSumW'(rce_pkg::ChanMax))
                 ? rce_pkg::ChanMax : brt_sum[i][rce_pkg::ChanW-1:0];
    end
    for (int i = 0; i < rce_pkg::NumChan; i++) begin
      res_next[i] = pix3[i];
    end
    unique case (mode3)
      rce_pkg::MODE_GRAY: begin
        for (int i = 0; i < rce_pkg::NumChan; i++) res_next[i] = avg3;
      end
      rce_pkg::MODE_BLUE_TINT: begin
        res_next[0] = avg3;
        res_next[1] = avg3;
      end
      rce_pkg::MODE_RED_TINT: begin
        res_next[1] = avg3;
        res_next[2] = avg3;
      end
      rce_pkg::MODE_SEPIA: begin
        for (int i = 0; i < rce_pkg::NumChan; i++) res_next[i] = sep_sat[i];
      end
      rce_pkg::MODE_BRIGHTEN: begin
        for (int i = 0; i < rce_pkg::NumChan; i++) res_next[i] = brt_sat[i];
      end
      default: begin
        for (int i = 0; i < rce_pkg::NumChan; i++) res_next[i] = pix3[i];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_red   <= res_next[0];
    out_green <= res_next[1];
    out_blue  <= res_next[2];
  end

endmodule

@@ sv/rgb_color_effect.sv @@
// rgb_color_effect: per-color effect unit, top level.
// The accepted color is registered through the rce_pipe stages; done marks the result.
// Throughput: one color per cycle; busy stays low, the pipeline never stalls.
// Reset: synchronous, clears the pipeline valid bits, effect_mode to none and
// brighten_percent to 60. Config registers are always ready.
// Depends on rce_pkg and rce_pipe.
module rgb_color_effect (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rce_pkg::ChanW-1:0]     in_red,
  input  logic [rce_pkg::ChanW-1:0]     in_green,
  input  logic [rce_pkg::ChanW-1:0]     in_blue,
  output logic                          done,
  output logic [rce_pkg::ChanW-1:0]     out_red,
  output logic [rce_pkg::ChanW-1:0]     out_green,
  output logic [rce_pkg::ChanW-1:0]     out_blue,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rce_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rce_pkg::CfgDataW-1:0]  cfg_data
);

  rce_pkg::rce_cfg_t cfg;
  logic              cfg_write;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= rce_pkg::MODE_NONE;
      cfg.pct  <= rce_pkg::PctReset;
    end else if (cfg_write) begin
      if (cfg_index == rce_pkg::REG_EFFECT_MODE) begin
        cfg.mode <= cfg_data[rce_pkg::ModeW-1:0];
      end
      if (cfg_index == rce_pkg::REG_BRIGHTEN) begin
        cfg.pct <= cfg_data[rce_pkg::PctW-1:0];
      end
    end
  end

  rce_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cfg       (cfg),
    .out_valid (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

@@ sv/rce_checker.sv @@
// rce_port_checker: port-level assertions for rgb_color_effect, bound to the top.
// Depends on rce_pkg.
module rce_port_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [rce_pkg::ChanW-1:0]     in_red,
  input logic [rce_pkg::ChanW-1:0]     in_green,
  input logic [rce_pkg::ChanW-1:0]     in_blue,
  input logic                          done,
  input logic [rce_pkg::ChanW-1:0]     out_red,
  input logic [rce_pkg::ChanW-1:0]     out_green,
  input logic [rce_pkg::ChanW-1:0]     out_blue,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [rce_pkg::CfgIdxW-1:0]   cfg_index,
  input logic [rce_pkg::CfgDataW-1:0]  cfg_data
);

  logic [rce_pkg::Latency-1:0] acc_sr;
  logic [rce_pkg::ModeW-1:0]   mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sr <= '0;
      mode   <= rce_pkg::MODE_NONE;
    end else begin
      acc_sr <= {acc_sr[rce_pkg::Latency-2:0], start && !busy};
      if (cfg_valid && cfg_ready && cfg_index == rce_pkg::REG_EFFECT_MODE) begin
        mode <= cfg_data[rce_pkg::ModeW-1:0];
      end
    end
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done == acc_sr[rce_pkg::Latency-1])
    else $error("done does not match accepted transaction");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    done && mode == rce_pkg::MODE_NONE |->
      out_red == $past(in_red, rce_pkg::Latency)
      && out_green == $past(in_green, rce_pkg::Latency)
      && out_blue == $past(in_blue, rce_pkg::Latency))
    else $error("passthrough color altered");

  a_gray_equal: assert property (@(posedge clk) disable iff (rst)
    done && mode == rce_pkg::MODE_GRAY |->
      out_red == out_green && out_green == out_blue)
    else $error("grayscale channels differ");

  a_sepia_order: assert property (@(posedge clk) disable iff (rst)
    done && mode == rce_pkg::MODE_SEPIA |->
      out_red >= out_green && out_green >= out_blue)
    else $error("sepia channel ordering violated");

endmodule

bind rgb_color_effect rce_port_checker u_rce_checker (.*);

@@ test/rce_checker.sv @@
// rce_checker: watches the color and config channels of rgb_color_effect,
// predicts each output color and compares it field by field with the DUT.
// Depends on rce_pkg.
module rce_checker
  import rce_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [ChanW-1:0]    in_red,
  input  logic [ChanW-1:0]    in_green,
  input  logic [ChanW-1:0]    in_blue,
  input  logic                done,
  input  logic [ChanW-1:0]    out_red,
  input  logic [ChanW-1:0]    out_green,
  input  logic [ChanW-1:0]    out_blue,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } color_t;

  logic [ModeW-1:0] mode_q;
  logic [PctW-1:0]  pct_q;
  color_t           expected_colors[$];
  int               err_count;

  function automatic logic [ChanW-1:0] clamp_chan(input int unsigned v);
    return (v > ChanMax) ? ChanMax : v[ChanW-1:0];
  endfunction

  function automatic logic [ChanW-1:0] sepia_chan(input color_t c,
                                                  input int unsigned kr, kg, kb);
    return clamp_chan((kr * c.red + kg * c.green + kb * c.blue) / 1000);
  endfunction

  function automatic logic [ChanW-1:0] bright_chan(input int unsigned c, p);
    return clamp_chan(c + (c * p) / 100);
  endfunction

  function automatic color_t effect_color(input logic [ModeW-1:0] mode,
                                          input logic [PctW-1:0] pct,
                                          input color_t c);
    int unsigned avg;
    color_t res;
    avg = (32'(c.red) + 32'(c.green) + 32'(c.blue)) / 3;
    res = c;
    case (mode)
      MODE_GRAY: begin
        res.red   = avg[ChanW-1:0];
        res.green = avg[ChanW-1:0];
        res.blue  = avg[ChanW-1:0];
      end
      MODE_BLUE_TINT: begin
        res.red   = avg[ChanW-1:0];
        res.green = avg[ChanW-1:0];
      end
      MODE_RED_TINT: begin
        res.green = avg[ChanW-1:0];
        res.blue  = avg[ChanW-1:0];
      end
      MODE_SEPIA: begin
        res.red   = sepia_chan(c, 393, 769, 189);
        res.green = sepia_chan(c, 349, 686, 168);
        res.blue  = sepia_chan(c, 272, 534, 131);
      end
      MODE_BRIGHTEN: begin
        res.red   = bright_chan(c.red, pct);
        res.green = bright_chan(c.green, pct);
        res.blue  = bright_chan(c.blue, pct);
      end
      default: ;  // spare codes pass through
    endcase
    return res;
  endfunction

  task automatic check_chan(input string name, input logic [ChanW-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    color_t want;
    if (rst) begin
      mode_q <= MODE_NONE;
      pct_q  <= PctReset;
      expected_colors.delete();
      err_count  = 0;
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_EFFECT_MODE) begin
          mode_q <= cfg_data[ModeW-1:0];
        end else if (cfg_index == REG_BRIGHTEN) begin
          pct_q <= cfg_data[PctW-1:0];
        end
      end
      if (start && !busy) begin
        expected_colors.push_back(effect_color(mode_q, pct_q,
                                               {in_red, in_green, in_blue}));
      end
      if (done) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: expected no color, got (%0d,%0d,%0d)",
                   $time, out_red, out_green, out_blue);
          err_count++;
        end else begin
          want = expected_colors.pop_front();
          check_chan("out_red", want.red, out_red);
          check_chan("out_green", want.green, out_green);
          check_chan("out_blue", want.blue, out_blue);
        end
      end
      mismatches <= err_count;
      pending    <= expected_colors.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// tb_top: stimulus for rgb_color_effect with directed and random colors
// over many effect settings; verdict from rce_checker. Depends on rce_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rce_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareLo  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi  = 2'd3;
  localparam logic [ModeW-1:0]   ModeSpareHi = 3'd7;
  localparam int                 RandomItems = 500;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ChanW-1:0]    in_red, in_green, in_blue;
  logic                done;
  logic [ChanW-1:0]    out_red, out_green, out_blue;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  mismatches;
  int                  pending;
  int                  gap_max;

  rgb_color_effect u_top (.*);
  rce_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_color(input logic [ChanW-1:0] r, g, b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        in_red   <= ChanW'($urandom);
        in_green <= ChanW'($urandom);
        in_blue  <= ChanW'($urandom);
        @(posedge clk);
      end
    end
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every predicted color has come back
  task automatic drain_results;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (Latency + 2) @(posedge clk);
  endtask

  function automatic logic [ChanW-1:0] rand_chan;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ChanMax;
      default: return ChanW'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int n;
    logic [ModeW-1:0]    next_mode;
    logic [CfgDataW-1:0] cfg_word;

    rst       = 1'b1;
    start     = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_EFFECT_MODE;
    cfg_data  = '0;
    gap_max   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: pass-through, then brighten at the reset percentage
    send_color(8'h00, 8'h00, 8'h00);
    send_color(8'hFF, 8'hFF, 8'hFF);
    send_color(8'hAA, 8'h55, 8'h0F);
    drain_results();
    write_reg(REG_EFFECT_MODE, CfgDataW'(MODE_BRIGHTEN));
    cfg_valid <= 1'b0;
    send_color(8'hFF, 8'h80, 8'h01);
    send_color(8'd100, 8'd159, 8'd160);

    // every mode code, spare ones included
    for (int m = 0; m <= ModeSpareHi; m++) begin
      drain_results();
      write_reg(REG_EFFECT_MODE, CfgDataW'(m));
      cfg_valid <= 1'b0;
      send_color(8'hFF, 8'hFF, 8'hFF);
      send_color(8'h80, 8'h01, 8'hFE);
    end

    // percent extremes, upper mode bits masked off, writes to unmapped indexes
    drain_results();
    write_reg(REG_BRIGHTEN, 8'd0);
    write_reg(REG_EFFECT_MODE, {5'h1F, MODE_BRIGHTEN});
    cfg_valid <= 1'b0;
    send_color(8'd200, 8'd37, 8'd99);
    drain_results();
    write_reg(REG_BRIGHTEN, 8'd255);
    write_reg(RegSpareLo, 8'h00);
    write_reg(RegSpareHi, 8'hFF);
    cfg_valid <= 1'b0;
    send_color(8'hFF, 8'h01, 8'd50);

    sent = 0;
    while (sent < RandomItems) begin
      drain_results();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          next_mode = ModeW'($urandom);
        end else begin
          next_mode = ModeW'($urandom_range(MODE_GRAY, MODE_BRIGHTEN));
        end
        cfg_word = CfgDataW'($urandom);
        cfg_word[ModeW-1:0] = next_mode;
        write_reg(REG_EFFECT_MODE, cfg_word);
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 5))
          0: write_reg(REG_BRIGHTEN, '0);
          1: write_reg(REG_BRIGHTEN, '1);
          default: write_reg(REG_BRIGHTEN, CfgDataW'($urandom));
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CfgIdxW'($urandom_range(RegSpareLo, RegSpareHi)), CfgDataW'($urandom));
      end
      cfg_valid <= 1'b0;
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      n = $urandom_range(10, 60);
      repeat (n) begin
        send_color(rand_chan(), rand_chan(), rand_chan());
        sent++;
      end
    end

    drain_results();
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
